// File: src/ptc_pkg.sv
// Package for the path traversal checker: character constants, fault and
// segment codes, item types and the percent-decoder and segment functions.
// No dependencies.
`default_nettype none

package ptc_pkg;

  // Characters of interest
  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_LA        = 8'h61;
  localparam logic [7:0] CH_LF        = 8'h66;
  localparam logic [7:0] CH_UA        = 8'h41;
  localparam logic [7:0] CH_UF        = 8'h46;

  // Segment tracker codes
  localparam logic [1:0] SEG_EMPTY  = 2'd0;
  localparam logic [1:0] SEG_DOT    = 2'd1;
  localparam logic [1:0] SEG_DOTDOT = 2'd2;
  localparam logic [1:0] SEG_OTHER  = 2'd3;

  // Fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_EMPTY = 2'd1;
  localparam logic [1:0] FAULT_DOT   = 2'd2;

  // One input item
  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_char;
    logic       is_last;
  } item_t;

  // Pending window of one decoder
  typedef struct packed {
    logic [7:0] w0;
    logic [7:0] w1;
    logic [1:0] cnt;
  } dec_t;

  // Decoder after one push, with up to three released bytes
  typedef struct packed {
    dec_t            d;
    logic [1:0]      n;
    logic [2:0][7:0] e;
  } push_t;

  // Segment tracker and fault latch
  typedef struct packed {
    logic [1:0] seg;
    logic [1:0] fault;
  } seg_t;

  // Second decoder plus segment tracker
  typedef struct packed {
    dec_t d2;
    seg_t s;
  } chain_t;

  // {valid, nibble} of a hex digit, either case
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // Push one byte into a percent-decoder
  function automatic push_t dec_push(dec_t d, logic [7:0] b);
    push_t      r;
    logic [4:0] h1;
    logic [4:0] h2;
    r   = '0;
    r.d = d;
    h1  = hex_val(d.w1);
    h2  = hex_val(b);
    case (d.cnt)
      2'd0: begin
        if (b == CH_PERCENT) begin
          r.d.w0  = b;
          r.d.cnt = 2'd1;
        end else begin
          r.e[0] = b;
          r.n    = 2'd1;
        end
      end
      2'd1: begin
        r.d.w1  = b;
        r.d.cnt = 2'd2;
      end
      default: begin
        if (h1[4] && h2[4]) begin
          r.e[0]  = {h1[3:0], h2[3:0]};
          r.n     = 2'd1;
          r.d.cnt = 2'd0;
        end else begin
          r.e[0] = CH_PERCENT;
          if (d.w1 == CH_PERCENT) begin
            // second '%' opens a new window
            r.n     = 2'd1;
            r.d.w0  = d.w1;
            r.d.w1  = b;
            r.d.cnt = 2'd2;
          end else begin
            r.e[1] = d.w1;
            if (b == CH_PERCENT) begin
              r.n     = 2'd2;
              r.d.w0  = b;
              r.d.cnt = 2'd1;
            end else begin
              r.e[2]  = b;
              r.n     = 2'd3;
              r.d.cnt = 2'd0;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  // Close the current segment
  function automatic seg_t seg_end(seg_t s);
    seg_t r;
    r = s;
    if (s.seg == SEG_DOT || s.seg == SEG_DOTDOT) begin
      r.fault = FAULT_DOT;
    end
    r.seg = SEG_EMPTY;
    return r;
  endfunction

  // Feed one decoded byte to the segment tracker
  function automatic seg_t seg_feed(seg_t s, logic [7:0] c);
    seg_t r;
    r = s;
    if (c == CH_SLASH || c == CH_BACKSLASH) begin
      r = seg_end(s);
    end else if (c == CH_DOT && s.seg == SEG_EMPTY) begin
      r.seg = SEG_DOT;
    end else if (c == CH_DOT && s.seg == SEG_DOT) begin
      r.seg = SEG_DOTDOT;
    end else begin
      r.seg = SEG_OTHER;
    end
    return r;
  endfunction

  // Push one byte into the second decoder and track what it releases
  function automatic chain_t second_feed(chain_t c, logic [7:0] b);
    chain_t r;
    push_t  p;
    r   = c;
    p   = dec_push(c.d2, b);
    r.d2 = p.d;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < p.n) begin
        r.s = seg_feed(r.s, p.e[i]);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/ptc_path_if.sv
// Input channel of the path traversal checker: valid/ready and one path item.
// No dependencies.
`default_nettype none

interface ptc_path_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       has_char;
  logic       is_last;

  modport source (output valid, char_byte, has_char, is_last, input ready);
  modport sink   (input valid, char_byte, has_char, is_last, output ready);
endinterface

`default_nettype wire

// File: src/ptc_verdict_if.sv
// Output channel of the path traversal checker: valid/ready and one verdict.
// No dependencies.
`default_nettype none

interface ptc_verdict_if;
  logic       valid;
  logic       ready;
  logic       path_ok;
  logic [1:0] fault_code;

  modport source (output valid, path_ok, fault_code, input ready);
  modport sink   (input valid, path_ok, fault_code, output ready);
endinterface

`default_nettype wire

// File: src/ptc_decode.sv
// Decode state of the path traversal checker: two cascaded percent-decoders,
// segment tracker and fault latch, updated once per advancing item.
// Depends on ptc_pkg.
`default_nettype none

module ptc_decode
  import ptc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire item_t      item,
  output      logic [1:0] fault_code
);

  dec_t first;
  dec_t first_next;
  dec_t second;
  seg_t segs;
  logic seen_any;
  logic seen_any_next;
  chain_t chain_next;

  // Whole per-item update, including end-of-path flush
  always_comb begin
    push_t  p1;
    chain_t c;
    seg_t   s_end;
    p1            = dec_push(first, item.char_byte);
    c.d2          = second;
    c.s           = segs;
    first_next    = first;
    seen_any_next = seen_any;
    s_end         = '0;
    fault_code    = FAULT_NONE;

    if (item.has_char) begin
      seen_any_next = 1'b1;
      first_next    = p1.d;
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < p1.n) begin
          c = second_feed(c, p1.e[i]);
        end
      end
    end

    if (item.is_last) begin
      // flush first decoder into the second, then the second into segments
      if (first_next.cnt >= 2'd1) c = second_feed(c, first_next.w0);
      if (first_next.cnt >= 2'd2) c = second_feed(c, first_next.w1);
      s_end = c.s;
      if (c.d2.cnt >= 2'd1) s_end = seg_feed(s_end, c.d2.w0);
      if (c.d2.cnt >= 2'd2) s_end = seg_feed(s_end, c.d2.w1);
      s_end      = seg_end(s_end);
      fault_code = seen_any_next ? s_end.fault : FAULT_EMPTY;
      // back to reset for the next path
      first_next    = '0;
      c             = '0;
      seen_any_next = 1'b0;
    end
    chain_next = c;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first    <= '0;
      second   <= '0;
      segs     <= '{seg: SEG_EMPTY, fault: FAULT_NONE};
      seen_any <= 1'b0;
    end else if (advance) begin
      first    <= first_next;
      second   <= chain_next.d2;
      segs     <= chain_next.s;
      seen_any <= seen_any_next;
    end
  end

endmodule

`default_nettype wire

// File: src/path_traversal_checker.sv
// Top level of the path traversal checker: input register, decode state and
// verdict register. Depends on ptc_pkg, ptc_path_if, ptc_verdict_if and ptc_decode.
`default_nettype none

// The block takes one path byte per cycle on path and gives one verdict on
// verdict for each item marked is_last. Each byte passes two cascaded
// percent-decoders; backslash counts as slash; a segment that is exactly "."
// or ".." rejects the path with fault_code 2, and a path with no byte at all
// is rejected with fault_code 1. An accepted item is held in the input
// register, the decode logic updates its state from it, and the verdict is
// then registered in the verdict register. Items are taken every cycle; the
// only stall is a last item that finds an earlier verdict still waiting in
// the verdict register.
module path_traversal_checker
  import ptc_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  ptc_path_if.sink    path,
  ptc_verdict_if.source verdict
);

  logic       in_valid;
  item_t      in_item;
  logic       fire;
  logic       out_valid;
  logic       out_ok;
  logic [1:0] out_code;
  logic [1:0] step_code;

  // Item leaves the input register unless a verdict would be overwritten
  assign fire       = in_valid && (!in_item.is_last || !out_valid || verdict.ready);
  assign path.ready = !in_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (path.ready) begin
      in_valid <= path.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (path.ready && path.valid) begin
      in_item <= '{char_byte: path.char_byte, has_char: path.has_char,
                   is_last: path.is_last};
    end
  end

  ptc_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .advance    (fire),
    .item       (in_item),
    .fault_code (step_code)
  );

  // Verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_item.is_last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_item.is_last) begin
      out_code <= step_code;
      out_ok   <= (step_code == FAULT_NONE);
    end
  end

  assign verdict.valid      = out_valid;
  assign verdict.path_ok    = out_ok;
  assign verdict.fault_code = out_code;

  // A waiting verdict is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_item.is_last && out_valid && !verdict.ready |-> !fire)
    else $error("verdict overwritten");

  // A last item always produces a verdict
  assert property (@(posedge clk) disable iff (rst)
    fire && in_item.is_last |=> out_valid)
    else $error("verdict lost");

  // path_ok agrees with the fault code
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ok == (out_code == FAULT_NONE)))
    else $error("path_ok and fault_code disagree");

  // Only defined fault codes leave the block
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_code == FAULT_NONE || out_code == FAULT_EMPTY ||
                   out_code == FAULT_DOT))
    else $error("undefined fault code");

endmodule

`default_nettype wire

// File: bench/ptc_checker.sv
// Scoreboard for the path traversal checker: watches both channels, predicts
// one verdict per path and compares it field by field with what comes out.
// Depends on ptc_pkg, ptc_path_if and ptc_verdict_if.
`default_nettype none

module ptc_checker
  import ptc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  ptc_path_if       path,
  ptc_verdict_if    verdict,
  output int        fails,
  output int        pending,
  output int        verdicts_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } verdict_rec_t;

  // Decoder stages: index 0 sees raw bytes, index 1 sees what stage 0 releases
  logic [7:0]   pct_hold0 [2];
  logic [7:0]   pct_hold1 [2];
  logic [1:0]   pct_fill  [2];
  logic [1:0]   seg_now;
  logic [1:0]   fault_now;
  logic         got_byte;
  verdict_rec_t due_verdicts [$];
  int           fail_count;
  int           seen_count;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
           (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic logic [3:0] nibble(logic [7:0] c);
    logic [7:0] v;
    if (c <= CH_9) begin
      v = c - CH_0;
    end else begin
      v = (c | 8'h20) - CH_LA + 8'd10;
    end
    return v[3:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ptc_checker: mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic clear_state();
    for (int s = 0; s < 2; s++) begin
      pct_hold0[s] = 8'h00;
      pct_hold1[s] = 8'h00;
      pct_fill[s]  = 2'd0;
    end
    seg_now   = SEG_EMPTY;
    fault_now = FAULT_NONE;
    got_byte  = 1'b0;
  endtask

  // One byte into a decoder stage; up to three bytes come back out
  task automatic decode_push(input int stg, input logic [7:0] b,
                             output logic [2:0][7:0] rel, output int n);
    rel = '0;
    n   = 0;
    case (pct_fill[stg])
      2'd0: begin
        if (b == CH_PERCENT) begin
          pct_hold0[stg] = b;
          pct_fill[stg]  = 2'd1;
        end else begin
          rel[0] = b;
          n      = 1;
        end
      end
      2'd1: begin
        pct_hold1[stg] = b;
        pct_fill[stg]  = 2'd2;
      end
      default: begin
        if (is_hex(pct_hold1[stg]) && is_hex(b)) begin
          rel[0]        = {nibble(pct_hold1[stg]), nibble(b)};
          n             = 1;
          pct_fill[stg] = 2'd0;
        end else begin
          // the '%' goes out bare; a later '%' among these bytes opens a new window
          rel[0] = CH_PERCENT;
          n      = 1;
          if (pct_hold1[stg] == CH_PERCENT) begin
            pct_hold0[stg] = CH_PERCENT;
            pct_hold1[stg] = b;
          end else begin
            rel[1] = pct_hold1[stg];
            n      = 2;
            if (b == CH_PERCENT) begin
              pct_hold0[stg] = b;
              pct_fill[stg]  = 2'd1;
            end else begin
              rel[2]        = b;
              n             = 3;
              pct_fill[stg] = 2'd0;
            end
          end
        end
      end
    endcase
  endtask

  // Release pending bytes of a stage as they are
  task automatic flush_stage(input int stg, output logic [2:0][7:0] rel,
                             output int n);
    rel = '0;
    n   = 0;
    if (pct_fill[stg] >= 2'd1) begin
      rel[0] = pct_hold0[stg];
      n      = 1;
    end
    if (pct_fill[stg] >= 2'd2) begin
      rel[1] = pct_hold1[stg];
      n      = 2;
    end
    pct_fill[stg] = 2'd0;
  endtask

  task automatic close_segment();
    if (seg_now == SEG_DOT || seg_now == SEG_DOTDOT) begin
      fault_now = FAULT_DOT;
    end
    seg_now = SEG_EMPTY;
  endtask

  // Segment tracking on fully decoded bytes
  task automatic track_byte(input logic [7:0] c);
    if (c == CH_SLASH || c == CH_BACKSLASH) begin
      close_segment();
    end else if (c == CH_DOT && seg_now == SEG_EMPTY) begin
      seg_now = SEG_DOT;
    end else if (c == CH_DOT && seg_now == SEG_DOT) begin
      seg_now = SEG_DOTDOT;
    end else begin
      seg_now = SEG_OTHER;
    end
  endtask

  task automatic inner_take(input logic [7:0] b);
    logic [2:0][7:0] rel;
    int              n;
    decode_push(1, b, rel, n);
    for (int i = 0; i < n; i++) begin
      track_byte(rel[i]);
    end
  endtask

  task automatic outer_take(input logic [7:0] b);
    logic [2:0][7:0] rel;
    int              n;
    decode_push(0, b, rel, n);
    for (int i = 0; i < n; i++) begin
      inner_take(rel[i]);
    end
  endtask

  // Predict the verdict for one accepted item, if it closes a path
  task automatic predict_verdict(input logic [7:0] b, input logic has,
                                 input logic last);
    logic [2:0][7:0] rel;
    int              n;
    verdict_rec_t    v;
    if (has) begin
      got_byte = 1'b1;
      outer_take(b);
    end
    if (last) begin
      flush_stage(0, rel, n);
      for (int i = 0; i < n; i++) begin
        inner_take(rel[i]);
      end
      flush_stage(1, rel, n);
      for (int i = 0; i < n; i++) begin
        track_byte(rel[i]);
      end
      close_segment();
      v.code = got_byte ? fault_now : FAULT_EMPTY;
      v.ok   = (v.code == FAULT_NONE);
      due_verdicts.insert(due_verdicts.size(), v);
      clear_state();
    end
  endtask

  task automatic check_verdict(input logic ok, input logic [1:0] code);
    verdict_rec_t want;
    seen_count++;
    if (due_verdicts.size() == 0) begin
      report_mismatch($sformatf("verdict with none due: path_ok %0b fault_code %0d",
                                ok, code));
    end else begin
      want = due_verdicts.pop_front();
      if (ok !== want.ok) begin
        report_mismatch($sformatf("path_ok %0b, expected %0b", ok, want.ok));
      end
      if (code !== want.code) begin
        report_mismatch($sformatf("fault_code %0d, expected %0d", code, want.code));
      end
    end
  endtask

  initial begin
    fail_count = 0;
    seen_count = 0;
    clear_state();
  end

  // Both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      due_verdicts.delete();
    end else begin
      if (verdict.valid && verdict.ready) begin
        check_verdict(verdict.path_ok, verdict.fault_code);
      end
      if (path.valid && path.ready) begin
        predict_verdict(path.char_byte, path.has_char, path.is_last);
      end
    end
    fails         <= fail_count;
    pending       <= due_verdicts.size();
    verdicts_seen <= seen_count;
  end

endmodule

`default_nettype wire

// File: bench/tb_path_traversal_checker.sv
// Testbench top for the path traversal checker: clock, reset, path stimulus,
// output back-pressure and the verdict. Depends on ptc_pkg, both channel
// interfaces, path_traversal_checker and ptc_checker.
`default_nettype none

module tb_path_traversal_checker
  import ptc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 100;
  localparam int TAIL_CYCLES    = 8;

  logic       clk;
  logic       rst;
  int         fails;
  int         pending;
  int         verdicts_seen;
  int         send_gap_pct;
  int         recv_stall_pct;
  int         items_sent;
  int         paths_sent;
  int         quiet_cycles;
  logic       hold_req;
  logic       hold_seen;
  int         hold_left;
  logic [7:0] path_buf [$];

  ptc_path_if    path_ch ();
  ptc_verdict_if verdict_ch ();

  path_traversal_checker u_dut (
    .clk     (clk),
    .rst     (rst),
    .path    (path_ch),
    .verdict (verdict_ch)
  );

  ptc_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .path          (path_ch),
    .verdict       (verdict_ch),
    .fails         (fails),
    .pending       (pending),
    .verdicts_seen (verdicts_seen)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      verdict_ch.ready <= 1'b0;
    end else begin
      verdict_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (path_ch.valid && path_ch.ready) ||
        (verdict_ch.valid && verdict_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d verdicts due", quiet_cycles, pending);
        $display("tb_path_traversal_checker: FAIL");
        $finish;
      end
    end
  end

  // Offer one item and hold it until it is taken
  task automatic push_item(input logic [7:0] b, input logic has, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      path_ch.valid <= 1'b0;
    end
    @(negedge clk);
    path_ch.valid     <= 1'b1;
    path_ch.char_byte <= b;
    path_ch.has_char  <= has;
    path_ch.is_last   <= last;
    @(posedge clk);
    while (!path_ch.ready) @(posedge clk);
    items_sent++;
    if (last) paths_sent++;
  endtask

  // Append one byte to the path buffer
  task automatic add_byte(input logic [7:0] b);
    path_buf.insert(path_buf.size(), b);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
  endtask

  // Send path_buf as one path; an empty buffer gives the empty path
  task automatic send_path(input logic empty_tail);
    int last_idx;
    last_idx = path_buf.size() - 1;
    if (path_buf.size() == 0) begin
      push_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end else begin
      for (int i = 0; i <= last_idx; i++) begin
        // the odd byte-less item mid-path, which the block skips
        if ($urandom_range(99) < 4) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
        push_item(path_buf[i], 1'b1, (i == last_idx) && !empty_tail);
      end
      if (empty_tail) push_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  task automatic append_separator();
    case ($urandom_range(5))
      0: append_text("/");
      1: append_text("\\");
      2: append_text("//");
      3: append_text("%2f");
      4: append_text("%5C");
      default: append_text("%252F");
    endcase
  endtask

  task automatic append_segment();
    int n;
    case ($urandom_range(15))
      0: append_text(".");
      1: append_text("..");
      2: append_text("%2e");
      3: append_text("%2E%2e");
      4: append_text(".%2E");
      5: append_text("%252e");
      6: append_text("%252E.");
      7: append_text("...");
      8: append_text(".x");
      9: append_text("%41b");
      10: append_text("%%2e");
      11: append_text("%zz");
      12: append_text("%2");
      13: begin
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) add_byte(8'($urandom_range(8'h7e, 8'h21)));
      end
      14: begin
        // percent with random neighbours, hex or not
        add_byte(CH_PERCENT);
        add_byte(8'($urandom_range(8'h7e, 8'h21)));
        add_byte(8'($urandom_range(8'h7e, 8'h21)));
      end
      default: add_byte(8'($urandom_range(255)));
    endcase
  endtask

  // Mostly segment-structured paths, some raw noise and some empty ones
  task automatic make_random_path();
    int kind;
    int nseg;
    kind = $urandom_range(99);
    path_buf.delete();
    if (kind < 8) begin
      nseg = $urandom_range(8, 1);
      for (int i = 0; i < nseg; i++) add_byte(8'($urandom_range(255)));
    end else if (kind >= 11) begin
      nseg = $urandom_range(4, 1);
      if ($urandom_range(1)) append_separator();
      for (int k = 0; k < nseg; k++) begin
        if (k > 0) append_separator();
        append_segment();
      end
      if ($urandom_range(4) == 0) append_separator();
    end
  endtask

  task automatic run_phase(input int gap, input int stall, input int target);
    int start;
    start          = items_sent;
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    while (items_sent - start < target) begin
      make_random_path();
      send_path($urandom_range(9) == 0);
    end
  endtask

  initial begin
    rst                  = 1'b1;
    path_ch.valid        = 1'b0;
    path_ch.char_byte    = 8'h00;
    path_ch.has_char     = 1'b0;
    path_ch.is_last      = 1'b0;
    verdict_ch.ready     = 1'b0;
    send_gap_pct         = 0;
    recv_stall_pct       = 0;
    items_sent           = 0;
    paths_sent           = 0;
    quiet_cycles         = 0;
    hold_req             = 1'b0;
    hold_seen            = 1'b0;
    hold_left            = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty path, dot segments plain and encoded once and twice
    path_buf.delete();
    send_path(1'b0);
    append_text(".");
    send_path(1'b0);
    path_buf.delete();
    append_text("/..");
    send_path(1'b0);
    path_buf.delete();
    append_text("%2e");
    send_path(1'b0);
    path_buf.delete();
    append_text("%252E");
    send_path(1'b0);
    // backslash separator, a skipped byte-less item, byte-less last item
    push_item("a", 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(CH_BACKSLASH, 1'b1, 1'b0);
    push_item("b", 1'b1, 1'b0);
    push_item(8'hA5, 1'b0, 1'b1);
    // a second percent reopens the window
    path_buf.delete();
    append_text("%%41");
    send_path(1'b0);
    // extreme byte values and a trailing percent left for the flush
    path_buf = '{8'hFF, 8'h00, CH_PERCENT};
    send_path(1'b0);

    // Random, no idling
    run_phase(0, 0, PHASE_ITEMS);

    // Long output hold-off while paths keep coming
    hold_req = ~hold_req;
    for (int p = 0; p < 12; p++) begin
      make_random_path();
      send_path(1'b0);
    end

    run_phase(51, 0, PHASE_ITEMS);
    run_phase(0, 51, PHASE_ITEMS);
    run_phase(7, 7, PHASE_ITEMS);

    @(negedge clk);
    path_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items in %0d paths; %0d verdicts checked.",
             items_sent, paths_sent, verdicts_seen);
    $display("Covered four idling mixes and one long output hold-off.");
    if (fails == 0) begin
      $display("tb_path_traversal_checker: PASS");
    end else begin
      $display("tb_path_traversal_checker: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
